### sv/cbtc_pkg.sv
// Package for the CAN bit timing calculator.
// Holds request and result payload types and shared constants; no dependencies.
`default_nettype none

package cbtc_pkg;

  localparam int DIV_W            = 32;
  localparam int DEF_MAX_QUANTA   = 73;
  localparam int DEF_MIN_QUANTA   = 4;
  localparam int SYNC_AND_OFFSETS = 3;
  localparam int PRESCALER_W      = 30;
  localparam int SEG_ONE_W        = 6;
  localparam int SEG_TWO_W        = 5;
  localparam int JUMP_W           = 2;

  localparam logic [JUMP_W-1:0] JUMP_WIDTH_VALUE = 2'd2;

  // Reciprocal for division by three of values below 256: (x * 171) >> 9.
  localparam logic [7:0] DIV3_RECIP = 8'd171;
  localparam int         DIV3_SHIFT = 9;

  typedef struct packed {
    logic [DIV_W-1:0] source_clock_hz;
    logic [DIV_W-1:0] bit_rate;
  } cbtc_req_t;

  typedef struct packed {
    logic [PRESCALER_W-1:0] prescaler;
    logic [SEG_ONE_W-1:0]   segment_one;
    logic [SEG_TWO_W-1:0]   segment_two;
    logic [JUMP_W-1:0]      jump_width;
    logic                   error;
  } cbtc_res_t;

endpackage : cbtc_pkg

`default_nettype wire

### sv/can_bit_timing_calculator_core.sv
// CAN bit timing calculator top level: one shared restoring divider under a sequencer.
// Depends on cbtc_pkg for payload types and constants.
//
// channel   ports                          transfer
// -------   -----------------------------  -----------------------------------
// request   start, busy, in_req            start high and busy low at clk edge
// result    out_valid, out_res             out_valid high for one cycle
//
// Sequence: one 32-step divide of clock by rate, then one 32-step divide of the
// quotient per bit length tried, longest first, each followed by an evaluation
// state, then a done state that forms the result; the search ends early on an
// exact match, and a zero input goes straight to the done state.
// The serial divider serves every divide; the segment split uses a reciprocal multiply.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_valid.
// The receiver cannot stall; busy stays high from a transfer until the result cycle.
`default_nettype none

module can_bit_timing_calculator_core
  import cbtc_pkg::*;
#(
  parameter int MAX_QUANTA = DEF_MAX_QUANTA,
  parameter int MIN_QUANTA = DEF_MIN_QUANTA
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire cbtc_req_t in_req,
  output logic           out_valid,
  output cbtc_res_t      out_res
);

  localparam int LEN_W = $clog2(MAX_QUANTA + 1);
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int MUL_W = 16;

  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_QUANTA);
  localparam logic [LEN_W-1:0] LEN_MIN  = LEN_W'(MIN_QUANTA);
  localparam logic [LEN_W-1:0] LEN_SYNC = LEN_W'(SYNC_AND_OFFSETS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EVAL,
    S_DONE
  } state_t;

  state_t           state_r,   state_nxt;
  logic [DIV_W-1:0] acc_r,     acc_nxt;      // partial remainder
  logic [DIV_W-1:0] quo_r,     quo_nxt;      // dividend in, quotient out
  logic [DIV_W-1:0] dvsr_r,    dvsr_nxt;
  logic [CNT_W-1:0] cnt_r,     cnt_nxt;
  logic             first_r,   first_nxt;    // divide of clock by rate
  logic             zero_r,    zero_nxt;
  logic             found_r,   found_nxt;
  logic [DIV_W-1:0] total_r,   total_nxt;
  logic [DIV_W-1:0] best_r,    best_nxt;
  logic [DIV_W-1:0] bquo_r,    bquo_nxt;
  logic [LEN_W-1:0] len_r,     len_nxt;
  logic [LEN_W-1:0] chosen_r,  chosen_nxt;
  logic             ovalid_r,  ovalid_nxt;
  cbtc_res_t        ores_r,    ores_nxt;

  // Shared divider step
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;
  logic             fits;

  // Segment split
  logic [LEN_W-1:0] span;
  logic [MUL_W-1:0] span_mul;
  logic [MUL_W-1:0] seg_two_full;
  logic [LEN_W-1:0] seg_two_len;
  logic [LEN_W-1:0] seg_one_len;
  logic             fail;

  always_comb begin
    shifted = {acc_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvsr_r};
    fits    = !trial[DIV_W];
  end

  always_comb begin
    span         = chosen_r - LEN_SYNC;
    span_mul     = MUL_W'(span) * MUL_W'(DIV3_RECIP);
    seg_two_full = span_mul >> DIV3_SHIFT;
    seg_two_len  = seg_two_full[LEN_W-1:0];
    seg_one_len  = span - seg_two_len;
    fail         = zero_r || !found_r || (bquo_r == '0);
  end

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    quo_nxt    = quo_r;
    dvsr_nxt   = dvsr_r;
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    zero_nxt   = zero_r;
    found_nxt  = found_r;
    total_nxt  = total_r;
    best_nxt   = best_r;
    bquo_nxt   = bquo_r;
    len_nxt    = len_r;
    chosen_nxt = chosen_r;
    ovalid_nxt = 1'b0;
    ores_nxt   = ores_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          zero_nxt  = (in_req.source_clock_hz == '0) || (in_req.bit_rate == '0);
          found_nxt = 1'b0;
          acc_nxt   = '0;
          quo_nxt   = in_req.source_clock_hz;
          dvsr_nxt  = in_req.bit_rate;
          cnt_nxt   = '0;
          first_nxt = 1'b1;
          state_nxt = zero_nxt ? S_DONE : S_DIV;
        end
      end

      S_DIV: begin
        acc_nxt = fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], fits};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        if (first_r) begin
          // Total prescaler ready; start the search at the longest bit
          total_nxt = quo_r;
          best_nxt  = dvsr_r;
          first_nxt = 1'b0;
          len_nxt   = LEN_MAX;
          acc_nxt   = '0;
          quo_nxt   = quo_r;
          dvsr_nxt  = DIV_W'(LEN_MAX);
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else if (acc_r == '0) begin
          chosen_nxt = len_r;
          bquo_nxt   = quo_r;
          found_nxt  = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          if (acc_r < best_r) begin
            best_nxt   = acc_r;
            chosen_nxt = len_r;
            bquo_nxt   = quo_r;
            found_nxt  = 1'b1;
          end
          if (len_r == LEN_MIN) begin
            state_nxt = S_DONE;
          end else begin
            len_nxt   = len_r - 1'b1;
            acc_nxt   = '0;
            quo_nxt   = total_r;
            dvsr_nxt  = DIV_W'(len_r - 1'b1);
            cnt_nxt   = '0;
            state_nxt = S_DIV;
          end
        end
      end

      S_DONE: begin
        ovalid_nxt          = 1'b1;
        ores_nxt.jump_width = JUMP_WIDTH_VALUE;
        ores_nxt.error      = fail;
        if (fail) begin
          ores_nxt.prescaler   = '0;
          ores_nxt.segment_one = '0;
          ores_nxt.segment_two = '0;
        end else begin
          ores_nxt.prescaler   = PRESCALER_W'(bquo_r - 1'b1);
          ores_nxt.segment_one = SEG_ONE_W'(seg_one_len);
          ores_nxt.segment_two = SEG_TWO_W'(seg_two_len);
        end
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      acc_r    <= acc_nxt;
      quo_r    <= quo_nxt;
      dvsr_r   <= dvsr_nxt;
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      zero_r   <= zero_nxt;
      found_r  <= found_nxt;
      total_r  <= total_nxt;
      best_r   <= best_nxt;
      bquo_r   <= bquo_nxt;
      len_r    <= len_nxt;
      chosen_r <= chosen_nxt;
      ores_r   <= ores_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_res   = ores_r;

  // A transfer raises busy in the cycle after it
  a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  // Result appears only as the sequencer returns to idle
  a_result_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_strobe_once : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_error_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.error) |->
      (out_res.prescaler == '0 && out_res.segment_one == '0 && out_res.segment_two == '0))
    else $error("error result carries nonzero timing");

  a_cnt_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r <= CNT_LAST))
    else $error("divider step count out of range");

endmodule : can_bit_timing_calculator_core

`default_nettype wire
